### hdl/fr_pkg.sv
package fr_pkg;

  localparam int FR_DATA_WIDTH = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } fr_div_stat_t;

endpackage

### hdl/fr_div.sv
module fr_div
  import fr_pkg::*;
#(
  parameter int DATA_WIDTH = FR_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output fr_div_stat_t          stat,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  busy;

  assign busy    = (cnt_r != '0);
  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DATA_WIDTH);
      end else if (busy) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy) begin
      quo_r <= {quo_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      rem_r <= diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hdl/fraction_reducer.sv
// A zero numerator or denominator goes from idle straight to the result state; otherwise the
// sequencer runs the Euclid remainder steps and then divides numerator and denominator by the GCD.
// Every remainder step and both final divisions run on one shared radix-2 divider,
// one quotient bit per cycle.
// Throughput: one item at a time; the next item is taken after the result is taken.
// Reset: synchronous, active low; the sequencer returns to idle and no result is pending.
module fraction_reducer
  import fr_pkg::*;
#(
  parameter int DATA_WIDTH = FR_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: numerator, denominator.
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: reduced_numerator, reduced_denominator.
  output logic [((2*DATA_WIDTH+6)/8)*8-1:0] out_tdata,
  // Fields from bit 0: status.
  output logic                             out_tuser
);

  localparam int OUT_W = ((2*DATA_WIDTH+6)/8)*8;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] nm_r, nm_nxt;
  logic [DATA_WIDTH-1:0] dm_r, dm_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] rn_r, rn_nxt;
  logic [DATA_WIDTH-2:0] rd_r, rd_nxt;
  logic                  status_r, status_nxt;

  logic [DATA_WIDTH-1:0] in_num;
  logic [DATA_WIDTH-1:0] in_den;
  logic [DATA_WIDTH-1:0] in_nm;
  logic [DATA_WIDTH-1:0] in_dm;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_dvd;
  logic [DATA_WIDTH-1:0] div_dvs;
  fr_div_stat_t          div_stat;
  logic [DATA_WIDTH-1:0] div_quo;
  logic [DATA_WIDTH-1:0] div_rem;

  assign in_num = in_tdata[DATA_WIDTH-1:0];
  assign in_den = in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign in_nm  = in_num[DATA_WIDTH-1] ? (~in_num + DATA_WIDTH'(1)) : in_num;
  assign in_dm  = in_den[DATA_WIDTH-1] ? (~in_den + DATA_WIDTH'(1)) : in_den;

  fr_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    nm_nxt     = nm_r;
    dm_nxt     = dm_r;
    b_nxt      = b_r;
    neg_nxt    = neg_r;
    rn_nxt     = rn_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    div_start  = 1'b0;
    div_dvd    = nm_r;
    div_dvs    = b_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          nm_nxt  = in_nm;
          dm_nxt  = in_dm;
          b_nxt   = in_dm;
          neg_nxt = in_num[DATA_WIDTH-1] ^ in_den[DATA_WIDTH-1];
          if (in_dm == '0) begin
            status_nxt = 1'b1;
            rn_nxt     = '0;
            rd_nxt     = '0;
            state_nxt  = S_OUT;
          end else if (in_nm == '0) begin
            status_nxt = 1'b0;
            rn_nxt     = '0;
            rd_nxt     = (DATA_WIDTH-1)'(1);
            state_nxt  = S_OUT;
          end else begin
            status_nxt = 1'b0;
            div_start  = 1'b1;
            div_dvd    = in_nm;
            div_dvs    = in_dm;
            state_nxt  = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          if (div_rem == '0) begin
            div_dvd   = nm_r;
            div_dvs   = b_r;
            state_nxt = S_DIVN;
          end else begin
            div_dvd = b_r;
            div_dvs = div_rem;
            b_nxt   = div_rem;
          end
        end
      end
      S_DIVN: begin
        if (div_stat.done) begin
          rn_nxt    = div_quo;
          div_start = 1'b1;
          div_dvd   = dm_r;
          div_dvs   = b_r;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_stat.done) begin
          rd_nxt = div_quo[DATA_WIDTH-1] ? MAX_POS[DATA_WIDTH-2:0]
                                         : div_quo[DATA_WIDTH-2:0];
          if (neg_r) begin
            rn_nxt = ~rn_r + DATA_WIDTH'(1);
          end else if (rn_r[DATA_WIDTH-1]) begin
            rn_nxt = MAX_POS;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nm_r     <= nm_nxt;
    dm_r     <= dm_nxt;
    b_r      <= b_nxt;
    neg_r    <= neg_nxt;
    rn_r     <= rn_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_W'({rd_r, rn_r});
  assign out_tuser  = status_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("error result carries nonzero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (rd_r != '0))
    else $error("valid result with zero denominator");

  a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !div_stat.busy)
    else $error("divider running outside a division state");
`endif

endmodule

### tb/sv/fr_checker.sv
module fr_checker
  import fr_pkg::*;
#(
  parameter int W = FR_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  // Fields from bit 0: numerator, denominator.
  input  logic [((2*W+7)/8)*8-1:0]     in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  // Fields from bit 0: reduced_numerator, reduced_denominator.
  input  logic [((2*W+6)/8)*8-1:0]     out_tdata,
  // Fields from bit 0: status.
  input  logic                         out_tuser,
  output int                           mismatches,
  output int                           results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic         status;
    logic [W-1:0] red_num;
    logic [W-2:0] red_den;
  } lowest_terms_t;

  lowest_terms_t lowest_terms_due [$];
  int            fault_count = 0;

  function automatic lowest_terms_t reduce_fraction(input logic [W-1:0] num,
                                                    input logic [W-1:0] den);
    logic [W-1:0]  num_mag;
    logic [W-1:0]  den_mag;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  rem;
    logic [W-1:0]  q_num;
    logic [W-1:0]  q_den;
    logic [W-1:0]  pos_max;
    lowest_terms_t res;
    pos_max = {1'b0, {(W-1){1'b1}}};
    num_mag = num[W-1] ? -num : num;
    den_mag = den[W-1] ? -den : den;
    if (den_mag == '0) begin
      res.status  = 1'b1;
      res.red_num = '0;
      res.red_den = '0;
      return res;
    end
    if (num_mag == '0) begin
      res.status  = 1'b0;
      res.red_num = '0;
      res.red_den = (W-1)'(1);
      return res;
    end
    a = num_mag;
    b = den_mag;
    while (b != '0) begin
      rem = a % b;
      a   = b;
      b   = rem;
    end
    q_num = num_mag / a;
    q_den = den_mag / a;
    if (q_den > pos_max) q_den = pos_max;
    if (num[W-1] != den[W-1]) begin
      q_num = -q_num;
    end else if (q_num > pos_max) begin
      q_num = pos_max;
    end
    res.status  = 1'b0;
    res.red_num = q_num;
    res.red_den = q_den[W-2:0];
    return res;
  endfunction

  always @(posedge clk) begin
    lowest_terms_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        lowest_terms_due.push_back(reduce_fraction(in_tdata[W-1:0], in_tdata[2*W-1:W]));
      end
      if (out_tvalid && out_tready) begin
        if (lowest_terms_due.size() == 0) begin
          $error("result item arrived with no fraction outstanding");
          fault_count++;
        end else begin
          want = lowest_terms_due.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fault_count++;
          end
          if (out_tdata[W-1:0] !== want.red_num) begin
            $error("reduced_numerator: expected %0d, got %0d",
                   $signed(want.red_num), $signed(out_tdata[W-1:0]));
            fault_count++;
          end
          if (out_tdata[2*W-2:W] !== want.red_den) begin
            $error("reduced_denominator: expected %0d, got %0d",
                   want.red_den, out_tdata[2*W-2:W]);
            fault_count++;
          end
        end
      end
    end
    mismatches  <= fault_count;
    results_due <= lowest_terms_due.size();
  end

endmodule

### tb/sv/tb_fraction_reducer.sv
module tb_fraction_reducer;
  timeunit 1ns;
  timeprecision 1ps;
  import fr_pkg::*;

  localparam int W           = FR_DATA_WIDTH;
  localparam int IN_BITS     = ((2*W+7)/8)*8;
  localparam int OUT_BITS    = ((2*W+6)/8)*8;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT = 20_000_000;

  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic                out_tuser;

  int          mismatches;
  int          results_due;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          ready_hold = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  fraction_reducer #(.DATA_WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  fr_checker #(.W(W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_hold <= $urandom_range(50, 400);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:      out_tready <= ~out_tready;
    endcase
  end

  task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {den, num};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_all_reduced();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  function automatic logic [W-1:0] multiple_of(input int unsigned factor);
    longint unsigned m;
    m = $urandom_range(0, 32'h7FFF_FFFF / factor);
    m = m * factor;
    return ($urandom_range(0, 1) == 1) ? W'(-m) : W'(m);
  endfunction

  function automatic logic [W-1:0] signed_power_of_two();
    logic [W-1:0] p;
    p = W'(1) << $urandom_range(0, W - 1);
    return ($urandom_range(0, 1) == 1) ? -p : p;
  endfunction

  logic [W-1:0] corner_num [$] = '{
    W'(0), W'(0), W'(5), W'(-5), W'(0), POS_MAX, W'(1), POS_MAX, POS_MAX, -POS_MAX,
    NEG_MIN, NEG_MIN, W'(1), W'(-3), NEG_MIN, W'(6), W'(-6), W'(6), W'(-6),
    W'(1836311903), W'(12), W'(32'h5555_5555), W'(-1), W'(7)
  };
  logic [W-1:0] corner_den [$] = '{
    W'(5), W'(-7), W'(0), W'(0), W'(0), W'(1), POS_MAX, POS_MAX, -POS_MAX, POS_MAX,
    W'(1), W'(-1), NEG_MIN, NEG_MIN, NEG_MIN, W'(4), W'(4), W'(-4), W'(-4),
    W'(1134903170), W'(36), W'(32'hAAAA_AAAA), W'(-1), W'(7)
  };

  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    int unsigned  pick;
    int unsigned  factor;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_num[i]) send_fraction(corner_num[i], corner_den[i]);
    wait_all_reduced();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        num = W'({$urandom, $urandom});
        den = W'({$urandom, $urandom});
      end else if (pick < 13) begin
        factor = $urandom_range(2, 1 << $urandom_range(1, 16));
        num = multiple_of(factor);
        den = multiple_of(factor);
      end else if (pick < 16) begin
        num = W'($signed($urandom_range(0, 200)) - 100);
        den = W'($signed($urandom_range(0, 200)) - 100);
      end else if (pick == 16) begin
        num = '0;
        den = W'({$urandom, $urandom});
      end else if (pick == 17) begin
        num = W'({$urandom, $urandom});
        den = '0;
      end else if (pick == 18) begin
        num = ($urandom_range(0, 1) == 1) ? NEG_MIN : signed_power_of_two();
        den = ($urandom_range(0, 1) == 1) ? NEG_MIN : W'({$urandom, $urandom});
      end else begin
        num = signed_power_of_two();
        den = signed_power_of_two();
      end
      send_fraction(num, den);
      if (i == RANDOM_ITEMS / 2) wait_all_reduced();
    end

    wait_all_reduced();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
